// ----- src/hs_pkg.sv -----
// ----------------------------------------------------------------------------
// hs_pkg
// shared widths, defaults and register indexes for histogram statistics
// ----------------------------------------------------------------------------
package hs_pkg;

    localparam int MAX_BINS_DEF   = 256;
    localparam int COUNT_BITS_DEF = 24;

    localparam int IN_DATA_W  = 24;
    localparam int VAL_W      = 32;
    localparam int STD_W      = 31;
    localparam int ENT_W      = 24;
    localparam int OUT_DATA_W = 120;
    localparam int OUT_USER_W = 2;
    localparam int CFG_IDX_W  = 1;

    localparam int ACC_W  = 64;
    localparam int WIDE_W = 128;
    localparam int LOG_FRAC = 24;
    localparam int LOG_INT_W = 6;
    localparam int LOG_W  = LOG_INT_W + LOG_FRAC;

    localparam logic [CFG_IDX_W-1:0] REG_RANGE_LOW  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_RANGE_HIGH = 1'b1;

    localparam logic [VAL_W-1:0] RANGE_LOW_RST  = 32'h0000_0000;
    localparam logic [VAL_W-1:0] RANGE_HIGH_RST = 32'h0001_0000;

endpackage

// ----- src/hs_ram.sv -----
// ----------------------------------------------------------------------------
// hs_ram
// simple dual port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module hs_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- src/hs_mul.sv -----
// ----------------------------------------------------------------------------
// hs_mul
// 64 x 64 unsigned multiplier, one 32 x 32 partial product per cycle
// ----------------------------------------------------------------------------
module hs_mul (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [hs_pkg::ACC_W-1:0]  a,
    input  logic [hs_pkg::ACC_W-1:0]  b,
    output logic                      done,
    output logic [hs_pkg::WIDE_W-1:0] p
);

    logic [hs_pkg::ACC_W-1:0]  a_reg;
    logic [hs_pkg::ACC_W-1:0]  b_reg;
    logic [hs_pkg::WIDE_W-1:0] acc_reg;
    logic [1:0]                step_reg;
    logic                      busy_reg;
    logic                      done_reg;

    logic [31:0]               a_part;
    logic [31:0]               b_part;
    logic [6:0]                shift;
    logic [63:0]               part;
    logic [hs_pkg::WIDE_W-1:0] part_sh;

    always_comb
    begin
        case (step_reg)
            2'd0:
            begin
                a_part = a_reg[31:0];
                b_part = b_reg[31:0];
                shift  = 7'd0;
            end
            2'd1:
            begin
                a_part = a_reg[31:0];
                b_part = b_reg[63:32];
                shift  = 7'd32;
            end
            2'd2:
            begin
                a_part = a_reg[63:32];
                b_part = b_reg[31:0];
                shift  = 7'd32;
            end
            default:
            begin
                a_part = a_reg[63:32];
                b_part = b_reg[63:32];
                shift  = 7'd64;
            end
        endcase
        part    = a_part * b_part;
        part_sh = {64'd0, part} << shift;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_reg    <= '0;
            b_reg    <= '0;
            acc_reg  <= '0;
            step_reg <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                a_reg    <= a;
                b_reg    <= b;
                acc_reg  <= '0;
                step_reg <= '0;
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                acc_reg  <= acc_reg + part_sh;
                step_reg <= step_reg + 2'd1;
                if (step_reg == 2'd3)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign p    = acc_reg;

endmodule

// ----- src/hs_div.sv -----
// ----------------------------------------------------------------------------
// hs_div
// restoring divider, 128 bit dividend by 64 bit divisor, one bit per cycle
// ----------------------------------------------------------------------------
module hs_div (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [hs_pkg::WIDE_W-1:0] dividend,
    input  logic [hs_pkg::ACC_W-1:0]  divisor,
    output logic                      done,
    output logic [hs_pkg::ACC_W-1:0]  quotient
);

    logic [hs_pkg::WIDE_W-1:0] num_reg;
    logic [hs_pkg::ACC_W-1:0]  rem_reg;
    logic [hs_pkg::ACC_W-1:0]  quo_reg;
    logic [hs_pkg::ACC_W-1:0]  den_reg;
    logic [6:0]                cnt_reg;
    logic                      busy_reg;
    logic                      done_reg;

    logic [hs_pkg::ACC_W-1:0]  trial;
    logic                      fits;

    assign trial = {rem_reg[hs_pkg::ACC_W-2:0], num_reg[hs_pkg::WIDE_W-1]};
    assign fits  = (trial >= den_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_reg  <= '0;
            rem_reg  <= '0;
            quo_reg  <= '0;
            den_reg  <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                num_reg  <= dividend;
                den_reg  <= divisor;
                rem_reg  <= '0;
                quo_reg  <= '0;
                cnt_reg  <= '0;
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                num_reg <= {num_reg[hs_pkg::WIDE_W-2:0], 1'b0};
                rem_reg <= fits ? trial - den_reg : trial;
                quo_reg <= {quo_reg[hs_pkg::ACC_W-2:0], fits};
                cnt_reg <= cnt_reg + 7'd1;
                if (cnt_reg == 7'd127)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ----- src/hs_sqrt.sv -----
// ----------------------------------------------------------------------------
// hs_sqrt
// integer square root of a 128 bit value, one root bit per cycle
// ----------------------------------------------------------------------------
module hs_sqrt (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [hs_pkg::WIDE_W-1:0] x,
    output logic                      done,
    output logic [hs_pkg::ACC_W-1:0]  root
);

    localparam int REM_W = hs_pkg::ACC_W + 2;

    logic [hs_pkg::WIDE_W-1:0] x_reg;
    logic [REM_W-1:0]          rem_reg;
    logic [hs_pkg::ACC_W-1:0]  root_reg;
    logic [5:0]                cnt_reg;
    logic                      busy_reg;
    logic                      done_reg;

    logic [REM_W+1:0]          rem_sh;
    logic [REM_W+1:0]          trial;
    logic                      fits;

    assign rem_sh = {rem_reg, x_reg[hs_pkg::WIDE_W-1 -: 2]};
    assign trial  = (REM_W+2)'({root_reg, 2'b01});
    assign fits   = (rem_sh >= trial);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_reg    <= '0;
            rem_reg  <= '0;
            root_reg <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                x_reg    <= x;
                rem_reg  <= '0;
                root_reg <= '0;
                cnt_reg  <= '0;
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                x_reg    <= {x_reg[hs_pkg::WIDE_W-3:0], 2'b00};
                rem_reg  <= fits ? REM_W'(rem_sh - trial) : REM_W'(rem_sh);
                root_reg <= {root_reg[hs_pkg::ACC_W-2:0], fits};
                cnt_reg  <= cnt_reg + 6'd1;
                if (cnt_reg == 6'd63)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

// ----- src/hs_log2.sv -----
// ----------------------------------------------------------------------------
// hs_log2
// fixed point log2 by normalization and repeated squaring of the mantissa
// ----------------------------------------------------------------------------
module hs_log2 (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [hs_pkg::ACC_W-1:0] x,
    output logic                     done,
    output logic [hs_pkg::LOG_W-1:0] value
);

    typedef enum logic [1:0] {
        LG_IDLE,
        LG_NORM,
        LG_SQ_S,
        LG_SQ_W
    } lg_state_t;

    lg_state_t                    state_reg;
    logic [62:0]                  m_reg;
    logic [hs_pkg::LOG_INT_W-1:0] n_reg;
    logic [hs_pkg::LOG_FRAC-1:0]  r_reg;
    logic [4:0]                   cnt_reg;
    logic                         done_reg;

    logic                         mul_done;
    logic [hs_pkg::WIDE_W-1:0]    mul_p;
    logic [63:0]                  sq;

    hs_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (state_reg == LG_SQ_S),
        .a     ({1'b0, m_reg}),
        .b     ({1'b0, m_reg}),
        .done  (mul_done),
        .p     (mul_p)
    );

    assign sq = mul_p[125:62];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= LG_IDLE;
            m_reg     <= '0;
            n_reg     <= '0;
            r_reg     <= '0;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                LG_IDLE:
                begin
                    if (start)
                    begin
                        m_reg     <= x[62:0];
                        n_reg     <= 6'd62;
                        r_reg     <= '0;
                        cnt_reg   <= '0;
                        state_reg <= LG_NORM;
                    end
                end
                LG_NORM:
                begin
                    if (m_reg[62])
                    begin
                        state_reg <= LG_SQ_S;
                    end
                    else
                    begin
                        m_reg <= {m_reg[61:0], 1'b0};
                        n_reg <= n_reg - 6'd1;
                    end
                end
                LG_SQ_S:
                begin
                    state_reg <= LG_SQ_W;
                end
                LG_SQ_W:
                begin
                    if (mul_done)
                    begin
                        r_reg   <= {r_reg[hs_pkg::LOG_FRAC-2:0], sq[63]};
                        m_reg   <= sq[63] ? sq[63:1] : sq[62:0];
                        cnt_reg <= cnt_reg + 5'd1;
                        if (cnt_reg == 5'(hs_pkg::LOG_FRAC - 1))
                        begin
                            done_reg  <= 1'b1;
                            state_reg <= LG_IDLE;
                        end
                        else
                        begin
                            state_reg <= LG_SQ_S;
                        end
                    end
                end
                default:
                begin
                    state_reg <= LG_IDLE;
                end
            endcase
        end
    end

    assign done  = done_reg;
    assign value = {n_reg, r_reg};

endmodule

// ----- src/histogram_statistics_top.sv -----
// ----------------------------------------------------------------------------
// histogram_statistics_top
// bins load at one per cycle into the count ram while the block is idle;
// after the last bin, a pass over the ram sums the total, then a pass per bin
// forms the mean and variance products and, when its count is nonzero, its log2
// term; then the log2 of the total, the divides and the square root give the result
// a new set may load while the result waits; reset clears control, not the ram
// ----------------------------------------------------------------------------
module histogram_statistics_top #(
    parameter int MAX_BINS   = hs_pkg::MAX_BINS_DEF,
    parameter int COUNT_BITS = hs_pkg::COUNT_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [hs_pkg::IN_DATA_W-1:0]  s_tdata,   // bin_count
    input  logic                          s_tlast,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [hs_pkg::OUT_DATA_W-1:0] m_tdata,   // mean_value, median_value,
                                                     // std_deviation, entropy_bits
    output logic [hs_pkg::OUT_USER_W-1:0] m_tuser,   // stats_valid, bins_overflowed
    input  logic                          cfg_we,
    input  logic [hs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [hs_pkg::VAL_W-1:0]      cfg_wdata
);

    localparam int AW    = $clog2(MAX_BINS);
    localparam int BIN_W = $clog2(MAX_BINS + 1);
    localparam int UW    = $clog2(2 * MAX_BINS);
    localparam int UU_W  = 2 * UW;
    localparam int ACC_W = hs_pkg::ACC_W;
    localparam int WIDE_W = hs_pkg::WIDE_W;

    typedef enum logic [5:0] {
        ST_IDLE, ST_T_RD, ST_T_ACC, ST_CHK, ST_DN_S, ST_DN_W,
        ST_B_RD, ST_B_CU_S, ST_B_CU_W, ST_B_CQ_S, ST_B_CQ_W,
        ST_B_LG_S, ST_B_LG_W, ST_B_CH_S, ST_B_CH_W, ST_B_NEXT,
        ST_LT_S, ST_LT_W, ST_TL_S, ST_TL_W,
        ST_MN_S, ST_MN_W, ST_MND_S, ST_MND_W,
        ST_MD_S, ST_MD_W, ST_MDD_S, ST_MDD_W,
        ST_TQ_S, ST_TQ_W, ST_MM_S, ST_MM_W, ST_NORM,
        ST_SQ_S, ST_SQ_W, ST_SD_S, ST_SD_W, ST_SDD_S, ST_SDD_W,
        ST_EN_S, ST_EN_W, ST_OUT
    } state_t;

    state_t                    state_reg;
    logic [hs_pkg::VAL_W-1:0]  range_low_reg;
    logic [hs_pkg::VAL_W-1:0]  range_high_reg;
    logic [BIN_W-1:0]          bins_reg;
    logic                      ovf_reg;
    logic [AW-1:0]             idx_reg;
    logic [UW-1:0]             u_reg;
    logic [UU_W-1:0]           uu_reg;
    logic [UW-1:0]             umed_reg;
    logic                      found_reg;
    logic [COUNT_BITS-1:0]     c_reg;
    logic [ACC_W-1:0]          total_reg;
    logic [ACC_W-1:0]          run_reg;
    logic [ACC_W-1:0]          msum_reg;
    logic [ACC_W-1:0]          qsum_reg;
    logic [WIDE_W-1:0]         hsum_reg;
    logic [WIDE_W-1:0]         tl_reg;
    logic [WIDE_W-1:0]         tq_reg;
    logic [WIDE_W-1:0]         x_reg;
    logic [5:0]                k_reg;
    logic [ACC_W-1:0]          denom_reg;
    logic                      sv_reg;
    logic [hs_pkg::VAL_W-1:0]  mean_reg;
    logic [hs_pkg::VAL_W-1:0]  median_reg;
    logic [hs_pkg::STD_W-1:0]  std_reg;
    logic [hs_pkg::ENT_W-1:0]  ent_reg;
    logic                      m_tvalid_reg;
    logic [hs_pkg::OUT_DATA_W-1:0] m_tdata_reg;
    logic [hs_pkg::OUT_USER_W-1:0] m_tuser_reg;

    logic                      ram_we;
    logic [COUNT_BITS-1:0]     rdata;
    logic                      full;
    logic                      idx_last;
    logic [32:0]               span;
    logic [32:0]               mag;
    logic [ACC_W-1:0]          run_sum;

    logic                      mul_start;
    logic [ACC_W-1:0]          mul_a;
    logic [ACC_W-1:0]          mul_b;
    logic                      mul_done;
    logic [WIDE_W-1:0]         mul_p;
    logic                      div_start;
    logic [WIDE_W-1:0]         div_n;
    logic [ACC_W-1:0]          div_d;
    logic                      div_done;
    logic [ACC_W-1:0]          div_q;
    logic                      log_start;
    logic [ACC_W-1:0]          log_x;
    logic                      log_done;
    logic [hs_pkg::LOG_W-1:0]  log_value;
    logic                      sqrt_done;
    logic [ACC_W-1:0]          sqrt_root;

    assign full     = (bins_reg == BIN_W'(MAX_BINS));
    assign ram_we   = (state_reg == ST_IDLE) && s_tvalid && !full;
    assign idx_last = ((BIN_W'(idx_reg) + BIN_W'(1)) == bins_reg);
    assign span     = {range_high_reg[31], range_high_reg} - {range_low_reg[31], range_low_reg};
    assign mag      = span[32] ? (~span + 33'd1) : span;
    assign run_sum  = run_reg + ACC_W'(c_reg);

    hs_ram #(
        .WIDTH (COUNT_BITS),
        .DEPTH (MAX_BINS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (bins_reg[AW-1:0]),
        .wdata (COUNT_BITS'(s_tdata)),
        .raddr (idx_reg),
        .rdata (rdata)
    );

    hs_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .done  (mul_done),
        .p     (mul_p)
    );

    hs_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_n),
        .divisor  (div_d),
        .done     (div_done),
        .quotient (div_q)
    );

    hs_log2 u_log2 (
        .clk   (clk),
        .rst_n (rst_n),
        .start (log_start),
        .x     (log_x),
        .done  (log_done),
        .value (log_value)
    );

    hs_sqrt u_sqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (state_reg == ST_SQ_S),
        .x     (x_reg),
        .done  (sqrt_done),
        .root  (sqrt_root)
    );

    // operand selection for the shared units
    always_comb
    begin
        mul_start = 1'b0;
        mul_a     = '0;
        mul_b     = '0;
        div_start = 1'b0;
        div_n     = '0;
        div_d     = '0;
        log_start = 1'b0;
        log_x     = '0;
        case (state_reg)
            ST_DN_S:
            begin
                mul_start = 1'b1;
                mul_a     = total_reg;
                mul_b     = ACC_W'(bins_reg);
            end
            ST_B_CU_S:
            begin
                mul_start = 1'b1;
                mul_a     = ACC_W'(rdata);
                mul_b     = ACC_W'(u_reg);
            end
            ST_B_CQ_S:
            begin
                mul_start = 1'b1;
                mul_a     = ACC_W'(c_reg);
                mul_b     = ACC_W'(uu_reg);
            end
            ST_B_LG_S:
            begin
                log_start = 1'b1;
                log_x     = ACC_W'(c_reg);
            end
            ST_B_CH_S:
            begin
                mul_start = 1'b1;
                mul_a     = ACC_W'(c_reg);
                mul_b     = ACC_W'(log_value);
            end
            ST_LT_S:
            begin
                log_start = 1'b1;
                log_x     = total_reg;
            end
            ST_TL_S:
            begin
                mul_start = 1'b1;
                mul_a     = total_reg;
                mul_b     = ACC_W'(log_value);
            end
            ST_MN_S:
            begin
                mul_start = 1'b1;
                mul_a     = ACC_W'(mag);
                mul_b     = msum_reg;
            end
            ST_MND_S:
            begin
                div_start = 1'b1;
                div_n     = mul_p;
                div_d     = denom_reg;
            end
            ST_MD_S:
            begin
                mul_start = 1'b1;
                mul_a     = ACC_W'(mag);
                mul_b     = ACC_W'(umed_reg);
            end
            ST_MDD_S:
            begin
                div_start = 1'b1;
                div_n     = mul_p;
                div_d     = ACC_W'({bins_reg, 1'b0});
            end
            ST_TQ_S:
            begin
                mul_start = 1'b1;
                mul_a     = qsum_reg;
                mul_b     = total_reg;
            end
            ST_MM_S:
            begin
                mul_start = 1'b1;
                mul_a     = msum_reg;
                mul_b     = msum_reg;
            end
            ST_SD_S:
            begin
                mul_start = 1'b1;
                mul_a     = ACC_W'(mag);
                mul_b     = sqrt_root;
            end
            ST_SDD_S:
            begin
                div_start = 1'b1;
                div_n     = mul_p >> k_reg;
                div_d     = denom_reg;
            end
            ST_EN_S:
            begin
                div_start = (tl_reg >= hsum_reg);
                div_n     = tl_reg - hsum_reg;
                div_d     = {total_reg[ACC_W-9:0], 8'd0};
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            range_low_reg  <= hs_pkg::RANGE_LOW_RST;
            range_high_reg <= hs_pkg::RANGE_HIGH_RST;
            bins_reg       <= '0;
            ovf_reg        <= 1'b0;
            idx_reg        <= '0;
            u_reg          <= '0;
            uu_reg         <= '0;
            umed_reg       <= '0;
            found_reg      <= 1'b0;
            c_reg          <= '0;
            total_reg      <= '0;
            run_reg        <= '0;
            msum_reg       <= '0;
            qsum_reg       <= '0;
            hsum_reg       <= '0;
            tl_reg         <= '0;
            tq_reg         <= '0;
            x_reg          <= '0;
            k_reg          <= '0;
            denom_reg      <= '0;
            sv_reg         <= 1'b0;
            mean_reg       <= '0;
            median_reg     <= '0;
            std_reg        <= '0;
            ent_reg        <= '0;
            m_tvalid_reg   <= 1'b0;
            m_tdata_reg    <= '0;
            m_tuser_reg    <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    hs_pkg::REG_RANGE_LOW:  range_low_reg  <= cfg_wdata;
                    hs_pkg::REG_RANGE_HIGH: range_high_reg <= cfg_wdata;
                    default:
                    begin
                    end
                endcase
            end

            if (m_tvalid_reg && m_tready && (state_reg != ST_OUT))
            begin
                m_tvalid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        if (full)
                        begin
                            ovf_reg <= 1'b1;
                        end
                        else
                        begin
                            bins_reg <= bins_reg + BIN_W'(1);
                        end
                        if (s_tlast)
                        begin
                            idx_reg   <= '0;
                            total_reg <= '0;
                            state_reg <= ST_T_RD;
                        end
                    end
                end
                ST_T_RD:
                begin
                    state_reg <= ST_T_ACC;
                end
                ST_T_ACC:
                begin
                    total_reg <= total_reg + ACC_W'(rdata);
                    if (idx_last)
                    begin
                        state_reg <= ST_CHK;
                    end
                    else
                    begin
                        idx_reg   <= idx_reg + AW'(1);
                        state_reg <= ST_T_RD;
                    end
                end
                ST_CHK:
                begin
                    sv_reg <= (total_reg != '0);
                    if (total_reg == '0)
                    begin
                        mean_reg   <= '0;
                        median_reg <= '0;
                        std_reg    <= '0;
                        ent_reg    <= '0;
                        state_reg  <= ST_OUT;
                    end
                    else
                    begin
                        state_reg <= ST_DN_S;
                    end
                end
                ST_DN_S:  state_reg <= ST_DN_W;
                ST_DN_W:
                begin
                    if (mul_done)
                    begin
                        denom_reg <= {mul_p[ACC_W-2:0], 1'b0};
                        idx_reg   <= '0;
                        u_reg     <= UW'(1);
                        uu_reg    <= UU_W'(1);
                        run_reg   <= '0;
                        msum_reg  <= '0;
                        qsum_reg  <= '0;
                        hsum_reg  <= '0;
                        found_reg <= 1'b0;
                        state_reg <= ST_B_RD;
                    end
                end
                ST_B_RD:  state_reg <= ST_B_CU_S;
                ST_B_CU_S:
                begin
                    c_reg     <= rdata;
                    state_reg <= ST_B_CU_W;
                end
                ST_B_CU_W:
                begin
                    if (mul_done)
                    begin
                        msum_reg <= msum_reg + mul_p[ACC_W-1:0];
                        run_reg  <= run_sum;
                        // median at the first bin where twice the running sum reaches total
                        if (!found_reg && ({run_sum, 1'b0} >= {1'b0, total_reg}))
                        begin
                            found_reg <= 1'b1;
                            umed_reg  <= u_reg;
                        end
                        state_reg <= ST_B_CQ_S;
                    end
                end
                ST_B_CQ_S: state_reg <= ST_B_CQ_W;
                ST_B_CQ_W:
                begin
                    if (mul_done)
                    begin
                        qsum_reg  <= qsum_reg + mul_p[ACC_W-1:0];
                        state_reg <= (c_reg != '0) ? ST_B_LG_S : ST_B_NEXT;
                    end
                end
                ST_B_LG_S: state_reg <= ST_B_LG_W;
                ST_B_LG_W:
                begin
                    if (log_done)
                    begin
                        state_reg <= ST_B_CH_S;
                    end
                end
                ST_B_CH_S: state_reg <= ST_B_CH_W;
                ST_B_CH_W:
                begin
                    if (mul_done)
                    begin
                        hsum_reg  <= hsum_reg + mul_p;
                        state_reg <= ST_B_NEXT;
                    end
                end
                ST_B_NEXT:
                begin
                    if (idx_last)
                    begin
                        state_reg <= ST_LT_S;
                    end
                    else
                    begin
                        idx_reg   <= idx_reg + AW'(1);
                        u_reg     <= u_reg + UW'(2);
                        uu_reg    <= uu_reg + UU_W'({u_reg, 2'b00}) + UU_W'(4);
                        state_reg <= ST_B_RD;
                    end
                end
                ST_LT_S:  state_reg <= ST_LT_W;
                ST_LT_W:
                begin
                    if (log_done)
                    begin
                        state_reg <= ST_TL_S;
                    end
                end
                ST_TL_S:  state_reg <= ST_TL_W;
                ST_TL_W:
                begin
                    if (mul_done)
                    begin
                        tl_reg    <= mul_p;
                        state_reg <= ST_MN_S;
                    end
                end
                ST_MN_S:  state_reg <= ST_MN_W;
                ST_MN_W:
                begin
                    if (mul_done)
                    begin
                        state_reg <= ST_MND_S;
                    end
                end
                ST_MND_S: state_reg <= ST_MND_W;
                ST_MND_W:
                begin
                    if (div_done)
                    begin
                        mean_reg  <= span[32] ? range_low_reg - div_q[31:0]
                                              : range_low_reg + div_q[31:0];
                        state_reg <= ST_MD_S;
                    end
                end
                ST_MD_S:  state_reg <= ST_MD_W;
                ST_MD_W:
                begin
                    if (mul_done)
                    begin
                        state_reg <= ST_MDD_S;
                    end
                end
                ST_MDD_S: state_reg <= ST_MDD_W;
                ST_MDD_W:
                begin
                    if (div_done)
                    begin
                        median_reg <= span[32] ? range_low_reg - div_q[31:0]
                                               : range_low_reg + div_q[31:0];
                        state_reg  <= ST_TQ_S;
                    end
                end
                ST_TQ_S:  state_reg <= ST_TQ_W;
                ST_TQ_W:
                begin
                    if (mul_done)
                    begin
                        tq_reg    <= mul_p;
                        state_reg <= ST_MM_S;
                    end
                end
                ST_MM_S:  state_reg <= ST_MM_W;
                ST_MM_W:
                begin
                    if (mul_done)
                    begin
                        if (tq_reg <= mul_p)
                        begin
                            std_reg   <= '0;
                            state_reg <= ST_EN_S;
                        end
                        else
                        begin
                            x_reg     <= tq_reg - mul_p;
                            k_reg     <= '0;
                            state_reg <= ST_NORM;
                        end
                    end
                end
                ST_NORM:
                begin
                    // scale by 4^k so the top bit pair is occupied, with k at most 63
                    if ((x_reg[WIDE_W-1 -: 2] == 2'b00) && (k_reg != 6'd63))
                    begin
                        x_reg <= {x_reg[WIDE_W-3:0], 2'b00};
                        k_reg <= k_reg + 6'd1;
                    end
                    else
                    begin
                        state_reg <= ST_SQ_S;
                    end
                end
                ST_SQ_S:  state_reg <= ST_SQ_W;
                ST_SQ_W:
                begin
                    if (sqrt_done)
                    begin
                        state_reg <= ST_SD_S;
                    end
                end
                ST_SD_S:  state_reg <= ST_SD_W;
                ST_SD_W:
                begin
                    if (mul_done)
                    begin
                        state_reg <= ST_SDD_S;
                    end
                end
                ST_SDD_S: state_reg <= ST_SDD_W;
                ST_SDD_W:
                begin
                    if (div_done)
                    begin
                        std_reg   <= div_q[hs_pkg::STD_W-1:0];
                        state_reg <= ST_EN_S;
                    end
                end
                ST_EN_S:
                begin
                    if (tl_reg >= hsum_reg)
                    begin
                        state_reg <= ST_EN_W;
                    end
                    else
                    begin
                        ent_reg   <= '0;
                        state_reg <= ST_OUT;
                    end
                end
                ST_EN_W:
                begin
                    if (div_done)
                    begin
                        ent_reg   <= div_q[hs_pkg::ENT_W-1:0];
                        state_reg <= ST_OUT;
                    end
                end
                ST_OUT:
                begin
                    if (!m_tvalid_reg || m_tready)
                    begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= {1'b0, ent_reg, std_reg, median_reg, mean_reg};
                        m_tuser_reg  <= {ovf_reg, sv_reg};
                        bins_reg     <= '0;
                        ovf_reg      <= 1'b0;
                        state_reg    <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

// ----- src/hs_checker.sv -----
// ----------------------------------------------------------------------------
// hs_checker
// port level checks for histogram statistics, bound to the top level
// ----------------------------------------------------------------------------
module hs_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          s_tlast,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [hs_pkg::OUT_DATA_W-1:0] m_tdata,
    input logic [hs_pkg::OUT_USER_W-1:0] m_tuser
);

    // closing transfer starts the computation, so input stalls
    a_last_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tlast |=> !s_tready)
        else $error("input ready after closing transfer");

    // a zero total yields all-zero statistics
    a_zero_stats: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[0] |-> m_tdata == '0)
        else $error("statistics nonzero with zero total");

    // a result only appears after input was held off
    a_result_after_compute: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result without computation");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

endmodule

bind histogram_statistics_top hs_checker u_hs_checker (.*);

// ----- dv/tb_histogram_statistics_top.sv -----
// ----------------------------------------------------------------------------
// tb_histogram_statistics_top
// streams histogram bin sets into the block under several range settings,
// predicts mean, median, std deviation and entropy per set and checks each
// result transfer field by field, with random idling and back pressure
// ----------------------------------------------------------------------------
module tb_histogram_statistics_top;

    localparam int NBINS = 256;

    typedef struct {
        logic [23:0] count;
        logic        last;
    } bin_item_t;

    typedef struct packed {
        logic        valid;
        logic        ovf;
        logic [31:0] mean;
        logic [31:0] median;
        logic [30:0] stdv;
        logic [23:0] ent;
    } stats_t;

    logic                          clk;
    logic                          rst_n;
    logic                          s_tvalid;
    logic                          s_tready;
    logic [hs_pkg::IN_DATA_W-1:0]  s_tdata;
    logic                          s_tlast;
    logic                          m_tvalid;
    logic                          m_tready;
    logic [hs_pkg::OUT_DATA_W-1:0] m_tdata;
    logic [hs_pkg::OUT_USER_W-1:0] m_tuser;
    logic                          cfg_we;
    logic [hs_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [hs_pkg::VAL_W-1:0]      cfg_wdata;

    histogram_statistics_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    bin_item_t   bin_q[$];
    stats_t      stats_q[$];
    logic [23:0] count_mem[NBINS];
    int          bins_held;
    logic        ovf_seen;
    longint      lo_val;
    longint      hi_val;
    int          mismatches;
    int          results_seen;
    int          sets_sent;
    int          items_sent;
    bit          quiet;
    bit          hold_req;
    int          hold_left;
    int          s_gap;
    int          m_gap;
    bit          s_taken;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [63:0] log2_q24(logic [63:0] x);
        int          n;
        logic [63:0] m;
        logic [63:0] r;
        logic [127:0] p;
        n = -1;
        for (int i = 0; i < 64; i++)
            if (x[i])
                n = i;
        if (n < 0)
            return 64'd0;
        m = (n <= 62) ? (x << (62 - n)) : (x >> (n - 62));
        r = 64'd0;
        for (int i = 0; i < 24; i++)
        begin
            p = {64'd0, m} * {64'd0, m};
            m = p[125:62];
            r = r << 1;
            if (m[63])
            begin
                r[0] = 1'b1;
                m = m >> 1;
            end
        end
        return (64'(n) << 24) | r;
    endfunction

    function automatic stats_t compute_stats();
        stats_t       st;
        logic [63:0]  total;
        logic [63:0]  msum;
        logic [63:0]  running;
        logic [63:0]  denom;
        logic [63:0]  mag;
        logic [63:0]  u;
        logic [63:0]  s;
        logic [63:0]  t;
        logic [127:0] qsum;
        logic [127:0] hsum;
        logic [127:0] tq;
        logic [127:0] mm;
        logic [127:0] nv;
        logic [127:0] x;
        logic [127:0] tl;
        longint       span;
        longint       off;
        bit           found;
        int           p;
        int           k;
        st = '0;
        st.ovf = ovf_seen;
        total = 0;
        for (int i = 0; i < bins_held; i++)
            total += count_mem[i];
        if (total == 0)
            return st;
        st.valid = 1'b1;
        span = hi_val - lo_val;
        mag = (span < 0) ? -span : span;
        msum = 0;
        running = 0;
        qsum = 0;
        hsum = 0;
        found = 0;
        for (int i = 0; i < bins_held; i++)
        begin
            u = 2 * i + 1;
            msum += count_mem[i] * u;
            qsum += {104'd0, count_mem[i]} * {64'd0, u * u};
            running += count_mem[i];
            if (!found && 2 * running >= total)
            begin
                st.median = 32'(lo_val + (span * longint'(u)) / (2 * bins_held));
                found = 1;
            end
            if (count_mem[i] != 0)
                hsum += {104'd0, count_mem[i]} * {64'd0, log2_q24(64'(count_mem[i]))};
        end
        denom = 2 * bins_held * total;
        off = longint'((({64'd0, mag} * {64'd0, msum}) / {64'd0, denom}));
        st.mean = 32'((span < 0) ? lo_val - off : lo_val + off);
        tq = {64'd0, total} * qsum;
        mm = {64'd0, msum} * {64'd0, msum};
        nv = (tq < mm) ? 128'd0 : tq - mm;
        if (nv != 0)
        begin
            p = 0;
            for (int i = 0; i < 128; i++)
                if (nv[i])
                    p = i;
            k = (127 - p) / 2;
            if (k > 63)
                k = 63;
            x = nv << (2 * k);
            s = 0;
            for (int b = 63; b >= 0; b--)
            begin
                t = s | (64'd1 << b);
                if (!(x < ({64'd0, t} * {64'd0, t})))
                    s = t;
            end
            st.stdv = 31'(((({64'd0, mag} * {64'd0, s}) >> k) / {64'd0, denom}));
        end
        tl = {64'd0, total} * {64'd0, log2_q24(total)};
        if (!(tl < hsum))
            st.ent = 24'((tl - hsum) / {64'd0, total << 8});
        return st;
    endfunction

    // bin stream and result checks
    always @(posedge clk)
    begin
        stats_t got;
        stats_t want;
        s_taken = s_tvalid && s_tready;
        if (s_tvalid && s_tready)
        begin
            if (bins_held < NBINS)
            begin
                count_mem[bins_held] = s_tdata;
                bins_held++;
            end
            else
                ovf_seen = 1'b1;
            if (s_tlast)
            begin
                stats_q.push_back(compute_stats());
                bins_held = 0;
                ovf_seen = 1'b0;
            end
        end
        if (m_tvalid && m_tready)
        begin
            results_seen++;
            got.valid  = m_tuser[0];
            got.ovf    = m_tuser[1];
            got.mean   = m_tdata[31:0];
            got.median = m_tdata[63:32];
            got.stdv   = m_tdata[94:64];
            got.ent    = m_tdata[118:95];
            if (stats_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result transfer at %0t", $time);
            end
            else
            begin
                want = stats_q.pop_front();
                if (got != want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch at %0t: exp v=%0b o=%0b mean=%h med=%h ",
                                  "std=%h ent=%h, got v=%0b o=%0b mean=%h med=%h ",
                                  "std=%h ent=%h"},
                                 $time, want.valid, want.ovf, want.mean, want.median,
                                 want.stdv, want.ent, got.valid, got.ovf, got.mean,
                                 got.median, got.stdv, got.ent);
                end
            end
        end
    end

    // sender
    always @(negedge clk)
    begin
        if (rst_n && (!s_tvalid || s_taken))
        begin
            if (s_gap > 0)
            begin
                s_gap--;
                s_tvalid <= 1'b0;
            end
            else if (!quiet && $urandom_range(0, 9) == 0)
            begin
                s_gap = $urandom_range(0, 17);
                s_tvalid <= 1'b0;
            end
            else if (bin_q.size() > 0)
            begin
                bin_item_t it;
                it = bin_q.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= it.count;
                s_tlast  <= it.last;
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // receiver
    always @(negedge clk)
    begin
        if (hold_req && hold_left == 0)
        begin
            hold_left = 3000;
            hold_req = 0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else if (m_gap > 0)
        begin
            m_gap--;
            m_tready <= 1'b0;
        end
        else if (!quiet && $urandom_range(0, 7) == 0)
        begin
            m_gap = $urandom_range(0, 17);
            m_tready <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    task automatic push_set(int n, int mode);
        bin_item_t it;
        for (int i = 0; i < n; i++)
        begin
            case (mode)
                0: it.count = 24'd0;
                1: it.count = 24'hFFFFFF;
                2: it.count = $urandom_range(0, 15);
                3: it.count = ($urandom_range(0, 2) == 0) ? 24'd0 : 24'($urandom);
                default: it.count = 24'($urandom);
            endcase
            it.last = (i == n - 1);
            bin_q.push_back(it);
        end
        sets_sent++;
        items_sent += n;
    endtask

    task automatic random_sets(int n_items);
        int goal;
        int pick;
        goal = items_sent + n_items;
        while (items_sent < goal)
        begin
            pick = $urandom_range(0, 59);
            if (pick == 0)
                push_set($urandom_range(257, 262), $urandom_range(0, 4));
            else if (pick < 3)
                push_set($urandom_range(200, 256), $urandom_range(2, 4));
            else
                push_set($urandom_range(1, 12), $urandom_range(0, 4));
        end
    endtask

    task automatic drain();
        do
            @(posedge clk);
        while (bin_q.size() != 0 || s_tvalid || stats_q.size() != 0);
        repeat (20) @(posedge clk);
    endtask

    task automatic set_range(logic [31:0] lo, logic [31:0] hi);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= hs_pkg::REG_RANGE_LOW;
        cfg_wdata <= lo;
        @(negedge clk);
        cfg_index <= hs_pkg::REG_RANGE_HIGH;
        cfg_wdata <= hi;
        @(negedge clk);
        cfg_we    <= 1'b0;
        lo_val = longint'(signed'(lo));
        hi_val = longint'(signed'(hi));
    endtask

    initial
    begin
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tlast = 1'b0;
        m_tready = 1'b0;
        cfg_we = 1'b0;
        cfg_index = hs_pkg::REG_RANGE_LOW;
        cfg_wdata = '0;
        bins_held = 0;
        ovf_seen = 1'b0;
        lo_val = 0;
        hi_val = 65536;
        mismatches = 0;
        results_seen = 0;
        sets_sent = 0;
        items_sent = 0;
        quiet = 0;
        hold_req = 0;
        hold_left = 0;
        s_gap = 0;
        m_gap = 0;
        s_taken = 0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed sets at the reset range
        push_set(1, 1);
        push_set(1, 0);
        push_set(4, 0);
        push_set(2, 1);
        push_set(3, 2);
        push_set(5, 4);
        push_set(6, 3);
        drain();

        set_range(32'h8000_0000, 32'h7FFF_FFFF);
        push_set(2, 1);
        hold_req = 1;
        random_sets(250);
        drain();

        set_range(32'h7FFF_FFFF, 32'h8000_0000);
        random_sets(250);
        drain();

        set_range(32'h0000_0000, 32'h0000_0000);
        random_sets(150);
        drain();

        set_range($urandom, $urandom);
        random_sets(250);
        drain();

        quiet = 1;
        set_range(32'hFFF0_0000, 32'h0010_0000);
        random_sets(300);
        drain();
        repeat (1000) @(posedge clk);

        $display("covered %0d bin transfers in %0d sets, %0d results checked",
                 items_sent, sets_sent, results_seen);
        $display("over 6 range settings including reversed and empty ranges");
        if (mismatches == 0 && stats_q.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        #200_000_000;
        $display("timeout");
        $display("Test completed with failures");
        $finish;
    end

endmodule
